>>> hdl/ffba_pkg.sv
// Package for the first-fit block allocator: codes, defaults and table entry type.
// No dependencies; the table, the allocator, the checker and the testbench import it.
package ffba_pkg;

	// defaults for the top-level parameters
	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 32;
	localparam int ADDRESS_BITS_DEF = 32;

	// register reset values
	localparam logic [31:0] RESET_MAX_REQUEST = 32'd100000000;
	localparam logic [31:0] RESET_HEAP_LIMIT  = 32'hFFFF_FFFF;

	// register indexes on the APB port
	localparam logic REG_MAX_REQUEST = 1'b0;
	localparam logic REG_HEAP_LIMIT  = 1'b1;

	// command codes
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_CALLOC  = 2'd1;
	localparam logic [1:0] CMD_REALLOC = 2'd2;
	localparam logic [1:0] CMD_FREE    = 2'd3;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_SIZE = 2'd1,
		STAT_ROOM = 2'd2,
		STAT_BAD  = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_MUL,
		FSM_PCHK,
		FSM_ACHK,
		FSM_ASCAN,
		FSM_APPEND,
		FSM_REL,
		FSM_FSCAN,
		FSM_DONE
	} fsm_t;

	// one row of the block table
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic        is_free;
	} entry_t;

	// request from the sequencer to the table memory
	typedef struct packed {
		logic   rd_en;
		logic   wr_en;
		entry_t wdata;
	} tbl_req_t;

endpackage

>>> hdl/ffba_req_if.sv
// Request channel of the allocator: valid/ready plus the command word.
// No dependencies.
interface ffba_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] request_size;
	logic [31:0] element_count;
	logic [31:0] block_address;

	modport source (output valid, cmd, request_size, element_count, block_address,
		input ready);
	modport sink (input valid, cmd, request_size, element_count, block_address,
		output ready);
endinterface

>>> hdl/ffba_rsp_if.sv
// Response channel of the allocator: valid/ready plus the result word.
// No dependencies.
interface ffba_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] result_address;
	logic [31:0] move_source;
	logic [31:0] move_bytes;
	logic [6:0]  free_block_count;
	logic [31:0] free_byte_count;
	logic [6:0]  total_block_count;
	logic [31:0] total_byte_count;
	logic [31:0] header_byte_count;

	modport source (output valid, status, result_address, move_source, move_bytes,
		free_block_count, free_byte_count, total_block_count, total_byte_count,
		header_byte_count, input ready);
	modport sink (input valid, status, result_address, move_source, move_bytes,
		free_block_count, free_byte_count, total_block_count, total_byte_count,
		header_byte_count, output ready);
endinterface

>>> hdl/ffba_table.sv
// Block table memory: one write port, one read port, registered read data.
// Depends on ffba_pkg.
module ffba_table
	import ffba_pkg::*;
#(
	parameter int DEPTH = MAX_BLOCKS_DEF,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  tbl_req_t      req,
	input  logic [IW-1:0] rd_idx,
	input  logic [IW-1:0] wr_idx,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wr_idx] <= req.wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata <= mem[rd_idx];
		end
	end

endmodule

>>> hdl/first_fit_block_allocator.sv
// First-fit block allocator. Keeps a table of heap blocks in address order in a
// single-port-read memory and serves allocate, count-times-size allocate,
// reallocate and free, one command at a time. Searches walk the table one entry
// per cycle through the memory read port. A moving reallocate walks the table twice:
// it finds the old block, then places the new one. After each result the block
// returns to idle, where it takes the next command.
// A new command is taken while the previous result still waits in the output
// register; a stalled output holds the next command in its done state.
// Depends on ffba_pkg, ffba_req_if, ffba_rsp_if and ffba_table.
module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ffba_req_if.sink    req,
	ffba_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [48:0] ADDR_MAX = (49'd1 << ADDRESS_BITS) - 49'd1;
	localparam logic [32:0] HDR33 = 33'(HEADER_BYTES);

	fsm_t state_q, state_d;

	// command word
	logic [1:0]  cmd_q;
	logic [31:0] req_q, cnt_q, baddr_q;
	logic [63:0] prod_q;
	logic        mv_q;
	logic [IW-1:0] k_q;
	logic [31:0] kstart_q, ksize_q;

	// result being built
	stat_t       status_q;
	logic [31:0] res_q, msrc_q, mbytes_q;

	// allocator state
	logic [CW-1:0] entry_count_q, free_entries_q;
	logic [31:0]   heap_top_q, free_payload_q, total_payload_q;
	logic [31:0]   max_request_q, heap_limit_q;

	// scan pipeline
	logic [CW-1:0] scan_idx_q;
	logic          rd_vld_s1;
	logic [IW-1:0] idx_s1;

	// output register
	logic          out_valid_q;
	stat_t         o_status_q;
	logic [31:0]   o_res_q, o_msrc_q, o_mbytes_q;
	logic [6:0]    o_fblk_q, o_tblk_q;
	logic [31:0]   o_fbyte_q, o_tbyte_q, o_hdr_q;

	tbl_req_t      tbl_req;
	logic [IW-1:0] wr_idx;
	entry_t        rdata;

	logic          accept, scanning, issue, a_hit, f_hit, exhaust, stop;
	logic          size_bad, room_ok, load;
	logic [32:0]   pay;
	logic [33:0]   new_top;

	ffba_table #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_table (
		.clk    (clk),
		.req    (tbl_req),
		.rd_idx (scan_idx_q[IW-1:0]),
		.wr_idx (wr_idx),
		.rdata  (rdata)
	);

	// scan and check conditions
	always_comb begin
		accept   = req.valid && req.ready;
		scanning = (state_q == FSM_ASCAN) || (state_q == FSM_FSCAN);
		issue    = scanning && (scan_idx_q < entry_count_q);
		pay      = {1'b0, rdata.start} + HDR33;
		a_hit    = (state_q == FSM_ASCAN) && rd_vld_s1 && rdata.is_free
			&& (rdata.size >= req_q);
		f_hit    = (state_q == FSM_FSCAN) && rd_vld_s1 && (pay == {1'b0, baddr_q});
		stop     = a_hit || f_hit;
		exhaust  = !rd_vld_s1 && (scan_idx_q >= entry_count_q);
		size_bad = (req_q == 32'd0) || (req_q > max_request_q);
		new_top  = 34'(heap_top_q) + 34'(HEADER_BYTES) + 34'(req_q);
		room_ok  = (entry_count_q < CW'(MAX_BLOCKS))
			&& (new_top <= {2'b00, heap_limit_q}) && (49'(new_top) <= ADDR_MAX);
		load     = !out_valid_q || rsp.ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_ALLOC:   state_d = FSM_ACHK;
						CMD_CALLOC:  state_d = FSM_MUL;
						CMD_REALLOC: state_d = (req.block_address == 32'd0) ? FSM_ACHK
							: FSM_FSCAN;
						default:     state_d = (req.block_address == 32'd0) ? FSM_DONE
							: FSM_FSCAN;
					endcase
				end
			end
			FSM_MUL:  state_d = FSM_PCHK;
			FSM_PCHK: state_d = (prod_q[63:32] != 32'd0) ? FSM_DONE : FSM_ACHK;
			FSM_ACHK: state_d = size_bad ? FSM_DONE : FSM_ASCAN;
			FSM_ASCAN: begin
				if (a_hit) begin
					state_d = mv_q ? FSM_REL : FSM_DONE;
				end else if (exhaust) begin
					state_d = FSM_APPEND;
				end
			end
			FSM_APPEND: state_d = (room_ok && mv_q) ? FSM_REL : FSM_DONE;
			FSM_REL:    state_d = FSM_DONE;
			FSM_FSCAN: begin
				if (f_hit) begin
					state_d = (rdata.is_free || cmd_q == CMD_FREE || rdata.size >= req_q)
						? FSM_DONE : FSM_ACHK;
				end else if (exhaust) begin
					state_d = FSM_DONE;
				end
			end
			FSM_DONE: state_d = load ? FSM_IDLE : FSM_DONE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	// handshake and table requests
	always_comb begin
		req.ready     = (state_q == FSM_IDLE);
		tbl_req.rd_en = issue;
		tbl_req.wr_en = 1'b0;
		tbl_req.wdata = rdata;
		wr_idx        = idx_s1;
		case (state_q)
			FSM_ASCAN: begin
				if (a_hit) begin
					tbl_req.wr_en         = 1'b1;
					tbl_req.wdata.is_free = 1'b0;
				end
			end
			FSM_APPEND: begin
				tbl_req.wr_en = room_ok;
				tbl_req.wdata = '{start: heap_top_q, size: req_q, is_free: 1'b0};
				wr_idx        = entry_count_q[IW-1:0];
			end
			FSM_REL: begin
				tbl_req.wr_en = 1'b1;
				tbl_req.wdata = '{start: kstart_q, size: ksize_q, is_free: 1'b1};
				wr_idx        = k_q;
			end
			FSM_FSCAN: begin
				if (f_hit && !rdata.is_free && cmd_q == CMD_FREE) begin
					tbl_req.wr_en         = 1'b1;
					tbl_req.wdata.is_free = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control state, counters and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= FSM_IDLE;
			scan_idx_q      <= '0;
			rd_vld_s1       <= 1'b0;
			mv_q            <= 1'b0;
			entry_count_q   <= '0;
			free_entries_q  <= '0;
			heap_top_q      <= '0;
			free_payload_q  <= '0;
			total_payload_q <= '0;
			max_request_q   <= RESET_MAX_REQUEST;
			heap_limit_q    <= RESET_HEAP_LIMIT;
			out_valid_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue && !stop;
			if (!scanning) begin
				scan_idx_q <= '0;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end

			if (accept) begin
				mv_q <= 1'b0;
			end
			case (state_q)
				FSM_ASCAN: begin
					if (a_hit) begin
						free_entries_q <= free_entries_q - CW'(1);
						free_payload_q <= free_payload_q - rdata.size;
					end
				end
				FSM_APPEND: begin
					if (room_ok) begin
						entry_count_q   <= entry_count_q + CW'(1);
						total_payload_q <= total_payload_q + req_q;
						heap_top_q      <= new_top[31:0];
					end
				end
				FSM_REL: begin
					free_entries_q <= free_entries_q + CW'(1);
					free_payload_q <= free_payload_q + ksize_q;
				end
				FSM_FSCAN: begin
					if (f_hit && !rdata.is_free) begin
						if (cmd_q == CMD_FREE) begin
							free_entries_q <= free_entries_q + CW'(1);
							free_payload_q <= free_payload_q + rdata.size;
						end else if (rdata.size < req_q) begin
							mv_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase

			// register writes
			if (psel && penable && pwrite) begin
				if (paddr[2] == REG_MAX_REQUEST) begin
					max_request_q <= pwdata;
				end else begin
					heap_limit_q <= pwdata;
				end
			end

			if (state_q == FSM_DONE && load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q[IW-1:0];
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					cmd_q    <= req.cmd;
					req_q    <= req.request_size;
					cnt_q    <= req.element_count;
					baddr_q  <= req.block_address;
					status_q <= STAT_OK;
					res_q    <= '0;
					msrc_q   <= '0;
					mbytes_q <= '0;
				end
			end
			FSM_MUL: prod_q <= 64'(cnt_q) * 64'(req_q);
			FSM_PCHK: begin
				if (prod_q[63:32] != 32'd0) begin
					status_q <= STAT_SIZE;
				end else begin
					req_q <= prod_q[31:0];
				end
			end
			FSM_ACHK: begin
				if (size_bad) begin
					status_q <= STAT_SIZE;
				end
			end
			FSM_ASCAN: begin
				if (a_hit) begin
					res_q <= pay[31:0];
				end
			end
			FSM_APPEND: begin
				if (room_ok) begin
					res_q <= heap_top_q + 32'(HEADER_BYTES);
				end else begin
					status_q <= STAT_ROOM;
				end
			end
			FSM_REL: begin
				msrc_q   <= baddr_q;
				mbytes_q <= ksize_q;
			end
			FSM_FSCAN: begin
				if (f_hit) begin
					if (rdata.is_free) begin
						status_q <= STAT_BAD;
					end else if (cmd_q == CMD_REALLOC) begin
						if (rdata.size >= req_q) begin
							res_q <= baddr_q;
						end else begin
							k_q      <= idx_s1;
							kstart_q <= rdata.start;
							ksize_q  <= rdata.size;
						end
					end
				end else if (exhaust) begin
					status_q <= STAT_BAD;
				end
			end
			FSM_DONE: begin
				if (load) begin
					o_status_q <= status_q;
					o_res_q    <= res_q;
					o_msrc_q   <= msrc_q;
					o_mbytes_q <= mbytes_q;
					o_fblk_q   <= 7'(free_entries_q);
					o_fbyte_q  <= free_payload_q;
					o_tblk_q   <= 7'(entry_count_q);
					o_tbyte_q  <= total_payload_q;
					o_hdr_q    <= 32'(64'(entry_count_q) * 64'(HEADER_BYTES));
				end
			end
			default: ;
		endcase
	end

	// response word
	assign rsp.valid             = out_valid_q;
	assign rsp.status            = o_status_q;
	assign rsp.result_address    = o_res_q;
	assign rsp.move_source       = o_msrc_q;
	assign rsp.move_bytes        = o_mbytes_q;
	assign rsp.free_block_count  = o_fblk_q;
	assign rsp.free_byte_count   = o_fbyte_q;
	assign rsp.total_block_count = o_tblk_q;
	assign rsp.total_byte_count  = o_tbyte_q;
	assign rsp.header_byte_count = o_hdr_q;

	// register read-back
	assign prdata = (paddr[2] == REG_MAX_REQUEST) ? max_request_q : heap_limit_q;
	assign pready = 1'b1;

endmodule

>>> hdl/ffba_chk.sv
// Port-level checks for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator.
module ffba_chk
	import ffba_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [1:0]  status,
	input logic [31:0] result_address,
	input logic [31:0] move_source,
	input logic [31:0] move_bytes,
	input logic [6:0]  free_block_count,
	input logic [6:0]  total_block_count
);

	// a result word stays valid until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("response dropped while stalled");

	// a failed command grants no address
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != STAT_OK |-> result_address == 32'd0)
		else $error("address granted on failure");

	// a copy is only reported for a successful move
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		valid && move_bytes != 32'd0 |-> status == STAT_OK && move_source != 32'd0)
		else $error("copy reported without a successful move");

	// free blocks never outnumber all blocks
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> free_block_count <= total_block_count)
		else $error("free block count above total");

endmodule

bind first_fit_block_allocator ffba_chk u_ffba_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.valid             (rsp.valid),
	.ready             (rsp.ready),
	.status            (rsp.status),
	.result_address    (rsp.result_address),
	.move_source       (rsp.move_source),
	.move_bytes        (rsp.move_bytes),
	.free_block_count  (rsp.free_block_count),
	.total_block_count (rsp.total_block_count)
);

>>> test/first_fit_block_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_block_allocator: directed table, then random traffic,
// checked word by word against an in-bench model of the block table.
// Depends on ffba_pkg, ffba_req_if, ffba_rsp_if and the allocator RTL.
module first_fit_block_allocator_tb;
	import ffba_pkg::*;

	localparam int NBLK = 64;
	localparam int HDR = 32;
	localparam int SETTLE = 2 * NBLK + 40;

	typedef struct {
		stat_t       status;
		logic [31:0] result_address;
		logic [31:0] move_source;
		logic [31:0] move_bytes;
		logic [6:0]  free_block_count;
		logic [31:0] free_byte_count;
		logic [6:0]  total_block_count;
		logic [31:0] total_byte_count;
		logic [31:0] header_byte_count;
	} alloc_word_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] size;
		logic [31:0] count;
		logic [31:0] baddr;
		bit          typed;
		stat_t       t_status;
		logic [31:0] t_addr;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ffba_req_if req ();
	ffba_rsp_if rsp ();

	first_fit_block_allocator dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// allocator shadow state
	logic [63:0] m_max_req, m_heap_limit;
	logic [63:0] blk_start [NBLK];
	logic [63:0] blk_size [NBLK];
	bit          blk_free [NBLK];
	int          blk_count;
	logic [63:0] heap_top, free_blocks, free_bytes, total_bytes;

	alloc_word_t pending_words[$];
	logic [31:0] granted[$];
	int fails = 0;

	function automatic stat_t grab_block(logic [63:0] size, output logic [63:0] addr);
		logic [63:0] new_top;
		addr = 0;
		if (size == 0 || size > m_max_req) return STAT_SIZE;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] && blk_size[i] >= size) begin
				blk_free[i] = 0;
				free_blocks--;
				free_bytes -= blk_size[i];
				addr = blk_start[i] + HDR;
				return STAT_OK;
			end
		end
		if (blk_count >= NBLK) return STAT_ROOM;
		new_top = heap_top + HDR + size;
		if (new_top > m_heap_limit || new_top > 64'hFFFF_FFFF) return STAT_ROOM;
		blk_start[blk_count] = heap_top;
		blk_size[blk_count] = size;
		blk_free[blk_count] = 0;
		blk_count++;
		total_bytes += size;
		addr = heap_top + HDR;
		heap_top = new_top;
		return STAT_OK;
	endfunction

	function automatic int find_payload(logic [31:0] a);
		for (int i = 0; i < blk_count; i++)
			if (blk_start[i] + HDR == {32'd0, a}) return i;
		return NBLK;
	endfunction

	function automatic alloc_word_t apply_cmd(logic [1:0] cmd, logic [31:0] size,
			logic [31:0] count, logic [31:0] baddr);
		alloc_word_t w;
		logic [63:0] res, msrc, mbytes, prod;
		int k;
		stat_t st;
		st = STAT_OK;
		res = 0; msrc = 0; mbytes = 0;
		case (cmd)
			CMD_ALLOC: st = grab_block({32'd0, size}, res);
			CMD_CALLOC: begin
				prod = {32'd0, count} * {32'd0, size};
				if (prod > 64'hFFFF_FFFF) st = STAT_SIZE;
				else st = grab_block(prod, res);
			end
			CMD_REALLOC: begin
				if (baddr == 0) st = grab_block({32'd0, size}, res);
				else begin
					k = find_payload(baddr);
					if (k >= NBLK || blk_free[k]) st = STAT_BAD;
					else if (blk_size[k] >= size) res = baddr;
					else begin
						st = grab_block({32'd0, size}, res);
						if (st == STAT_OK) begin
							msrc = baddr;
							mbytes = blk_size[k];
							blk_free[k] = 1;
							free_blocks++;
							free_bytes += blk_size[k];
						end
					end
				end
			end
			default: begin
				if (baddr != 0) begin
					k = find_payload(baddr);
					if (k >= NBLK || blk_free[k]) st = STAT_BAD;
					else begin
						blk_free[k] = 1;
						free_blocks++;
						free_bytes += blk_size[k];
					end
				end
			end
		endcase
		w.status = st;
		w.result_address = res[31:0];
		w.move_source = msrc[31:0];
		w.move_bytes = mbytes[31:0];
		w.free_block_count = free_blocks[6:0];
		w.free_byte_count = free_bytes[31:0];
		w.total_block_count = blk_count[6:0];
		w.total_byte_count = total_bytes[31:0];
		w.header_byte_count = blk_count * HDR;
		return w;
	endfunction

	// burst / gap state of the request side
	int burst_left = 0;

	task automatic issue(cmd_row_t r);
		alloc_word_t w;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.cmd <= r.cmd;
		req.request_size <= r.size;
		req.element_count <= r.count;
		req.block_address <= r.baddr;
		// ready is settled mid-cycle; the word goes at the next rising edge
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
		w = apply_cmd(r.cmd, r.size, r.count, r.baddr);
		if (r.typed) begin
			w.status = r.t_status;
			w.result_address = r.t_addr;
		end
		if (w.status == STAT_OK && w.result_address != 0) granted.push_back(w.result_address);
		pending_words.push_back(w);
	endtask

	// drain outstanding words, then let any search in flight finish
	task automatic go_idle();
		req.valid <= 1'b0;
		burst_left = 0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] a, logic [31:0] d);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (a == 3'd0) m_max_req = {32'd0, d};
		else m_heap_limit = {32'd0, d};
	endtask

	function automatic logic [31:0] pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6 || granted.size() == 0) return 32'd0;
		if (r < 12) return $urandom();
		return granted[$urandom_range(0, granted.size() - 1)];
	endfunction

	function automatic logic [31:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return 32'd0;
		if (r < 10) return $urandom();
		if (r < 80) return $urandom_range(1, 256);
		return $urandom_range(1, 4096);
	endfunction

	task automatic random_traffic(int n);
		cmd_row_t r;
		int sel;
		repeat (n) begin
			r = '{t_status: STAT_OK, default: '0};
			sel = $urandom_range(0, 99);
			if (sel < 33) begin
				r.cmd = CMD_ALLOC; r.size = pick_size();
			end else if (sel < 43) begin
				r.cmd = CMD_CALLOC;
				if ($urandom_range(0, 9) == 0) begin
					r.size = $urandom(); r.count = $urandom();
				end else begin
					r.size = $urandom_range(0, 64); r.count = $urandom_range(0, 8);
				end
			end else if (sel < 63) begin
				r.cmd = CMD_REALLOC; r.size = pick_size(); r.baddr = pick_addr();
			end else if (sel < 90) begin
				r.cmd = CMD_FREE; r.baddr = pick_addr();
			end else begin
				r.cmd = 2'($urandom()); r.size = $urandom();
				r.count = $urandom(); r.baddr = $urandom();
			end
			if (r.cmd != CMD_CALLOC && $urandom_range(0, 3) == 0) r.count = $urandom();
			issue(r);
		end
	endtask

	// directed rows; status and address typed in where obvious
	cmd_row_t directed[$] = '{
		'{CMD_ALLOC,   32'd0,         32'd0,         32'd0,         1, STAT_SIZE, 32'd0},
		'{CMD_ALLOC,   32'd100000001, 32'd0,         32'd0,         1, STAT_SIZE, 32'd0},
		'{CMD_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STAT_SIZE, 32'd0},
		'{CMD_ALLOC,   32'd1,         32'd0,         32'd0,         1, STAT_OK,   32'd32},
		'{CMD_FREE,    32'd0,         32'd0,         32'd0,         1, STAT_OK,   32'd0},
		'{CMD_FREE,    32'd0,         32'd0,         32'hFFFF_FFFF, 1, STAT_BAD,  32'd0},
		'{CMD_FREE,    32'd0,         32'd0,         32'd32,        1, STAT_OK,   32'd0},
		'{CMD_FREE,    32'd0,         32'd0,         32'd32,        1, STAT_BAD,  32'd0},
		'{CMD_ALLOC,   32'd100000000, 32'd0,         32'd0,         0, STAT_OK,   32'd0},
		'{CMD_CALLOC,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,         1, STAT_SIZE, 32'd0},
		'{CMD_CALLOC,  32'd16,        32'd0,         32'd0,         1, STAT_SIZE, 32'd0},
		'{CMD_CALLOC,  32'h0001_0000, 32'h0001_0000, 32'd0,         1, STAT_SIZE, 32'd0},
		'{CMD_CALLOC,  32'd1,         32'd1,         32'd0,         1, STAT_OK,   32'd32},
		'{CMD_REALLOC, 32'd8,         32'd0,         32'd0,         0, STAT_OK,   32'd0},
		'{CMD_REALLOC, 32'd0,         32'd0,         32'd32,        1, STAT_OK,   32'd32},
		'{CMD_REALLOC, 32'd1,         32'd0,         32'd32,        1, STAT_OK,   32'd32},
		'{CMD_REALLOC, 32'd500,       32'd0,         32'd32,        0, STAT_OK,   32'd0},
		'{CMD_REALLOC, 32'd4,         32'd0,         32'd32,        1, STAT_BAD,  32'd0},
		'{CMD_REALLOC, 32'd4,         32'd0,         32'd12345,     1, STAT_BAD,  32'd0},
		'{CMD_FREE,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,         1, STAT_OK,   32'd0}
	};

	// response checker
	always @(posedge clk) begin
		alloc_word_t e;
		if (rsp.valid && rsp.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, status %0d addr %h", $time, rsp.status,
					rsp.result_address);
				fails++;
			end else begin
				e = pending_words.pop_front();
				if (rsp.status !== e.status || rsp.result_address !== e.result_address ||
						rsp.move_source !== e.move_source || rsp.move_bytes !== e.move_bytes ||
						rsp.free_block_count !== e.free_block_count ||
						rsp.free_byte_count !== e.free_byte_count ||
						rsp.total_block_count !== e.total_block_count ||
						rsp.total_byte_count !== e.total_byte_count ||
						rsp.header_byte_count !== e.header_byte_count) begin
					$display("%0t: expected st %0d adr %h src %h mb %h fb %0d fy %h tb %0d ty %h hd %h",
						$time, e.status, e.result_address, e.move_source, e.move_bytes,
						e.free_block_count, e.free_byte_count, e.total_block_count,
						e.total_byte_count, e.header_byte_count);
					$display("%0t: actual   st %0d adr %h src %h mb %h fb %0d fy %h tb %0d ty %h hd %h",
						$time, rsp.status, rsp.result_address, rsp.move_source, rsp.move_bytes,
						rsp.free_block_count, rsp.free_byte_count, rsp.total_block_count,
						rsp.total_byte_count, rsp.header_byte_count);
					fails++;
				end
			end
		end
	end

	// receiver stalls: the mode is redrawn when its random countdown runs out
	int stall_mode = 0, stall_left = 0;
	initial rsp.ready = 1'b0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(10, 80);
		end else
			stall_left <= stall_left - 1;
		case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= $urandom_range(0, 1);
			2: rsp.ready <= ($urandom_range(0, 7) == 0);
			default: rsp.ready <= (stall_left % 6) < 3;
		endcase
	end

	initial begin
		req.valid = 1'b0;
		req.cmd = CMD_ALLOC;
		req.request_size = '0;
		req.element_count = '0;
		req.block_address = '0;
		m_max_req = {32'd0, RESET_MAX_REQUEST};
		m_heap_limit = {32'd0, RESET_HEAP_LIMIT};
		blk_count = 0;
		heap_top = 0; free_blocks = 0; free_bytes = 0; total_bytes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) issue(directed[i]);
		random_traffic(150);

		// widest limits: huge requests may now reach the room check
		go_idle();
		reg_write(3'd0, 32'hFFFF_FFFF);
		reg_write(3'd4, 32'hFFFF_FFFF);
		random_traffic(120);

		// nothing passes the size check
		go_idle();
		reg_write(3'd0, 32'd0);
		random_traffic(20);

		// no growth allowed, only reuse of free blocks
		go_idle();
		reg_write(3'd0, 32'd500);
		reg_write(3'd4, 32'd0);
		random_traffic(80);

		// back to reset values
		go_idle();
		reg_write(3'd0, RESET_MAX_REQUEST);
		reg_write(3'd4, RESET_HEAP_LIMIT);
		random_traffic(80);

		go_idle();
		if (fails == 0)
			$display("[first_fit_block_allocator] OK");
		else
			$display("[first_fit_block_allocator] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[first_fit_block_allocator] ERROR");
		$finish;
	end
endmodule
